// ----- hw/rtl/hsnd_pkg.sv -----
// Shared types, letter constants and lookup functions for the Hangul
// syllable name decoder. No dependencies; used by hsnd_parser and the top.
`timescale 1ns / 1ps

package hsnd_pkg;

  typedef logic [6:0] letter_t;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_START  = 3'd1,
    PH_HELD   = 3'd2,
    PH_VOWEL  = 3'd3,
    PH_FINAL  = 3'd4,
    PH_ENDED  = 3'd5
  } phase_e;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } lookup_t;

  // Parser state as it stands after the last character of a name
  typedef struct packed {
    logic              ok;
    logic [4:0]        init_idx;
    letter_t [2:0]     vowel;
    logic [1:0]        vcnt;
    letter_t [1:0]     fin;
    logic [1:0]        fcnt;
  } hsnd_snap_t;

  localparam logic [15:0] SBase       = 16'hAC00;
  localparam logic [15:0] SLast       = 16'hD7A3;
  localparam logic [4:0]  NoInitial   = 5'd11;
  localparam logic [4:0]  InitCount   = 5'd19;
  localparam logic [4:0]  VowelCount  = 5'd21;
  localparam logic [4:0]  FinalCount  = 5'd28;
  localparam int          PrefixLen   = 16;

  localparam letter_t CH_A = 7'h41;
  localparam letter_t CH_B = 7'h42;
  localparam letter_t CH_C = 7'h43;
  localparam letter_t CH_D = 7'h44;
  localparam letter_t CH_E = 7'h45;
  localparam letter_t CH_G = 7'h47;
  localparam letter_t CH_H = 7'h48;
  localparam letter_t CH_I = 7'h49;
  localparam letter_t CH_J = 7'h4A;
  localparam letter_t CH_K = 7'h4B;
  localparam letter_t CH_L = 7'h4C;
  localparam letter_t CH_M = 7'h4D;
  localparam letter_t CH_N = 7'h4E;
  localparam letter_t CH_O = 7'h4F;
  localparam letter_t CH_P = 7'h50;
  localparam letter_t CH_R = 7'h52;
  localparam letter_t CH_S = 7'h53;
  localparam letter_t CH_T = 7'h54;
  localparam letter_t CH_U = 7'h55;
  localparam letter_t CH_W = 7'h57;
  localparam letter_t CH_Y = 7'h59;
  localparam letter_t CH_USCORE = 7'h5F;

  // HANGUL_SYLLABLE_
  function automatic letter_t prefix_char(input logic [3:0] pos);
    letter_t r;
    case (pos)
      4'd0:    r = CH_H;
      4'd1:    r = CH_A;
      4'd2:    r = CH_N;
      4'd3:    r = CH_G;
      4'd4:    r = CH_U;
      4'd5:    r = CH_L;
      4'd6:    r = CH_USCORE;
      4'd7:    r = CH_S;
      4'd8:    r = CH_Y;
      4'd9:    r = CH_L;
      4'd10:   r = CH_L;
      4'd11:   r = CH_A;
      4'd12:   r = CH_B;
      4'd13:   r = CH_L;
      4'd14:   r = CH_E;
      default: r = CH_USCORE;
    endcase
    return r;
  endfunction

  function automatic logic is_consonant(input letter_t c);
    return (c == CH_G) || (c == CH_N) || (c == CH_D) || (c == CH_R) || (c == CH_M) ||
           (c == CH_B) || (c == CH_S) || (c == CH_J) || (c == CH_C) || (c == CH_K) ||
           (c == CH_T) || (c == CH_P) || (c == CH_H);
  endfunction

  function automatic logic is_vowel_letter(input letter_t c);
    return (c == CH_A) || (c == CH_E) || (c == CH_I) || (c == CH_O) || (c == CH_U) ||
           (c == CH_W) || (c == CH_Y);
  endfunction

  function automatic lookup_t init_single(input letter_t c);
    lookup_t r;
    r = '{hit: 1'b1, idx: 5'd0};
    case (c)
      CH_G:    r.idx = 5'd0;
      CH_N:    r.idx = 5'd2;
      CH_D:    r.idx = 5'd3;
      CH_R:    r.idx = 5'd5;
      CH_M:    r.idx = 5'd6;
      CH_B:    r.idx = 5'd7;
      CH_S:    r.idx = 5'd9;
      CH_J:    r.idx = 5'd12;
      CH_C:    r.idx = 5'd14;
      CH_K:    r.idx = 5'd15;
      CH_T:    r.idx = 5'd16;
      CH_P:    r.idx = 5'd17;
      CH_H:    r.idx = 5'd18;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // Only GG, DD, BB, SS and JJ exist as doubled initials
  function automatic lookup_t init_double(input letter_t c);
    lookup_t r;
    r = '{hit: 1'b1, idx: 5'd0};
    case (c)
      CH_G:    r.idx = 5'd1;
      CH_D:    r.idx = 5'd4;
      CH_B:    r.idx = 5'd8;
      CH_S:    r.idx = 5'd10;
      CH_J:    r.idx = 5'd13;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic lookup_t vowel_lookup(input letter_t [2:0] v, input logic [1:0] cnt);
    lookup_t r;
    r = '{hit: 1'b1, idx: 5'd0};
    case (cnt)
      2'd1: begin
        case (v[0])
          CH_A:    r.idx = 5'd0;
          CH_E:    r.idx = 5'd5;
          CH_O:    r.idx = 5'd8;
          CH_U:    r.idx = 5'd13;
          CH_I:    r.idx = 5'd20;
          default: r.hit = 1'b0;
        endcase
      end
      2'd2: begin
        case ({v[0], v[1]})
          {CH_A, CH_E}: r.idx = 5'd1;
          {CH_Y, CH_A}: r.idx = 5'd2;
          {CH_E, CH_O}: r.idx = 5'd4;
          {CH_Y, CH_E}: r.idx = 5'd7;
          {CH_W, CH_A}: r.idx = 5'd9;
          {CH_O, CH_E}: r.idx = 5'd11;
          {CH_Y, CH_O}: r.idx = 5'd12;
          {CH_W, CH_E}: r.idx = 5'd15;
          {CH_W, CH_I}: r.idx = 5'd16;
          {CH_Y, CH_U}: r.idx = 5'd17;
          {CH_E, CH_U}: r.idx = 5'd18;
          {CH_Y, CH_I}: r.idx = 5'd19;
          default:      r.hit = 1'b0;
        endcase
      end
      2'd3: begin
        case ({v[0], v[1], v[2]})
          {CH_Y, CH_A, CH_E}: r.idx = 5'd3;
          {CH_Y, CH_E, CH_O}: r.idx = 5'd6;
          {CH_W, CH_A, CH_E}: r.idx = 5'd10;
          {CH_W, CH_E, CH_O}: r.idx = 5'd14;
          default:            r.hit = 1'b0;
        endcase
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic lookup_t final_lookup(input letter_t [1:0] f, input logic [1:0] cnt);
    lookup_t r;
    r = '{hit: 1'b1, idx: 5'd0};
    case (cnt)
      2'd0: r.idx = 5'd0;
      2'd1: begin
        case (f[0])
          CH_G:    r.idx = 5'd1;
          CH_N:    r.idx = 5'd4;
          CH_D:    r.idx = 5'd7;
          CH_L:    r.idx = 5'd8;
          CH_M:    r.idx = 5'd16;
          CH_B:    r.idx = 5'd17;
          CH_S:    r.idx = 5'd19;
          CH_J:    r.idx = 5'd22;
          CH_C:    r.idx = 5'd23;
          CH_K:    r.idx = 5'd24;
          CH_T:    r.idx = 5'd25;
          CH_P:    r.idx = 5'd26;
          CH_H:    r.idx = 5'd27;
          default: r.hit = 1'b0;
        endcase
      end
      2'd2: begin
        case ({f[0], f[1]})
          {CH_G, CH_G}: r.idx = 5'd2;
          {CH_G, CH_S}: r.idx = 5'd3;
          {CH_N, CH_J}: r.idx = 5'd5;
          {CH_N, CH_H}: r.idx = 5'd6;
          {CH_L, CH_G}: r.idx = 5'd9;
          {CH_L, CH_M}: r.idx = 5'd10;
          {CH_L, CH_B}: r.idx = 5'd11;
          {CH_L, CH_S}: r.idx = 5'd12;
          {CH_L, CH_T}: r.idx = 5'd13;
          {CH_L, CH_P}: r.idx = 5'd14;
          {CH_L, CH_H}: r.idx = 5'd15;
          {CH_B, CH_S}: r.idx = 5'd18;
          {CH_S, CH_S}: r.idx = 5'd20;
          {CH_N, CH_G}: r.idx = 5'd21;
          default:      r.hit = 1'b0;
        endcase
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/hsnd_parser.sv -----
// Character-by-character name parser: prefix match, initial, vowel and
// final letter collection. Depends on hsnd_pkg.
`timescale 1ns / 1ps

module hsnd_parser
  import hsnd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [15:0] char_i,
  input  logic        last_i,
  output hsnd_snap_t  snap_o
);

  phase_e          phase_q, phase_d;
  logic [3:0]      pos_q, pos_d;
  logic [4:0]      init_q, init_d;
  logic [1:0]      vcnt_q, vcnt_d;
  logic [1:0]      fcnt_q, fcnt_d;
  logic            rej_q, rej_d;
  letter_t         held_q, held_d;
  letter_t [2:0]   vl_q, vl_d;
  letter_t [1:0]   fl_q, fl_d;

  logic [15:0]     u;
  letter_t         a7;
  logic            reject_now;
  lookup_t         lk;

  // ASCII-only case folding
  assign u  = (char_i >= 16'h0061 && char_i <= 16'h007A) ? char_i - 16'h0020 : char_i;
  assign a7 = u[6:0];

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    init_d     = init_q;
    vcnt_d     = vcnt_q;
    fcnt_d     = fcnt_q;
    rej_d      = rej_q;
    held_d     = held_q;
    vl_d       = vl_q;
    fl_d       = fl_q;
    reject_now = 1'b0;
    lk         = '0;

    if (accept_i && !rej_q && phase_q != PH_ENDED) begin
      if (char_i == 16'h0000) begin
        // a zero ends the name early; before any vowel it is invalid
        if (phase_q == PH_PREFIX || phase_q == PH_START || phase_q == PH_HELD) begin
          reject_now = 1'b1;
        end else begin
          phase_d = PH_ENDED;
        end
      end else if (phase_q == PH_PREFIX) begin
        if (u == {9'd0, prefix_char(pos_q)}) begin
          pos_d = pos_q + 4'd1;
          if (pos_q == 4'(PrefixLen - 1)) phase_d = PH_START;
        end else begin
          reject_now = 1'b1;
        end
      end else if (|u[15:7]) begin
        reject_now = 1'b1;
      end else begin
        case (phase_q)
          PH_START: begin
            if (is_consonant(a7)) begin
              held_d  = a7;
              phase_d = PH_HELD;
            end else begin
              init_d   = NoInitial;
              vl_d[0]  = a7;
              vcnt_d   = 2'd1;
              phase_d  = PH_VOWEL;
            end
          end
          PH_HELD: begin
            if (a7 == held_q) begin
              lk = init_double(held_q);
            end else begin
              lk = init_single(held_q);
            end
            if (!lk.hit) begin
              reject_now = 1'b1;
            end else begin
              init_d  = lk.idx;
              phase_d = PH_VOWEL;
              if (a7 != held_q) begin
                vl_d[0] = a7;
                vcnt_d  = 2'd1;
              end
            end
          end
          PH_VOWEL: begin
            if (vcnt_q == 2'd0) begin
              vl_d[0] = a7;
              vcnt_d  = 2'd1;
            end else if (vcnt_q != 2'd3 && is_vowel_letter(a7)) begin
              case (vcnt_q)
                2'd1:    vl_d[1] = a7;
                default: vl_d[2] = a7;
              endcase
              vcnt_d = vcnt_q + 2'd1;
            end else begin
              fl_d[0] = a7;
              fcnt_d  = 2'd1;
              phase_d = PH_FINAL;
            end
          end
          PH_FINAL: begin
            if (fcnt_q != 2'd2) begin
              fl_d[fcnt_q[0]] = a7;
              fcnt_d          = fcnt_q + 2'd1;
            end else begin
              reject_now = 1'b1;
            end
          end
          default: reject_now = 1'b1;
        endcase
      end
    end

    if (reject_now) begin
      rej_d   = 1'b1;
      phase_d = PH_ENDED;
    end
  end

  // Snapshot reflects the last character already folded in
  always_comb begin
    snap_o.ok       = !rej_d &&
                      (phase_d == PH_VOWEL || phase_d == PH_FINAL || phase_d == PH_ENDED);
    snap_o.init_idx = init_d;
    snap_o.vowel    = vl_d;
    snap_o.vcnt     = vcnt_d;
    snap_o.fin      = fl_d;
    snap_o.fcnt     = fcnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      pos_q   <= '0;
      init_q  <= NoInitial;
      vcnt_q  <= '0;
      fcnt_q  <= '0;
      rej_q   <= 1'b0;
    end else if (accept_i && last_i) begin
      phase_q <= PH_PREFIX;
      pos_q   <= '0;
      init_q  <= NoInitial;
      vcnt_q  <= '0;
      fcnt_q  <= '0;
      rej_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      init_q  <= init_d;
      vcnt_q  <= vcnt_d;
      fcnt_q  <= fcnt_d;
      rej_q   <= rej_d;
    end
  end

  // Letter storage: only read below the fill counts, so no reset
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    vl_q   <= vl_d;
    fl_q   <= fl_d;
  end

endmodule

// ----- hw/rtl/hangul_syllable_name_decoder_unit.sv -----
// Hangul syllable name decoder.
//
// Input stream: one UTF-16 character of a character name per item on
// s_axis_*, tlast set on the final character. The name must read
// HANGUL_SYLLABLE_ followed by initial, vowel and final letters (ASCII
// case-insensitive). A zero character ends the name early.
// Output stream: one item per name on m_axis_*: tuser = found, tdata =
// composed code point (0xAC00 + (L*21+V)*28 + T), zero when not found.
//
// Throughput: one character per cycle until both stages hold results. Each
// character updates the parser registers in the cycle it is accepted; the last
// one also loads an evaluation register, and the table lookups and index
// arithmetic then fill the output register, which drives m_axis_tvalid.
// A stalled receiver holds the output register; the evaluation register keeps
// accepting, so input stalls only once both hold results.
// Reset clears the parser to the start of a name and empties both stages.
// Depends on hsnd_pkg and hsnd_parser.
`timescale 1ns / 1ps

module hangul_syllable_name_decoder_unit
  import hsnd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] name_char
  input  logic        s_axis_tlast,   // end_of_name
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_point
  output logic        m_axis_tuser    // [0] found
);

  hsnd_snap_t  snap_d, snap_q;
  logic        e_valid_q;
  logic        o_valid_q;
  logic        found_q;
  logic [15:0] code_q;

  logic        accept;
  logic        e_ready;
  logic        o_ready;

  lookup_t     vi;
  lookup_t     ti;
  logic        hit;
  logic [8:0]  lv;
  logic [13:0] offs;
  logic [15:0] code_d;

  assign o_ready       = !o_valid_q || m_axis_tready;
  assign e_ready       = !e_valid_q || o_ready;
  assign s_axis_tready = e_ready;
  assign accept        = s_axis_tvalid && e_ready;

  hsnd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .snap_o   (snap_d)
  );

  // Table lookups and syllable composition
  always_comb begin
    vi     = vowel_lookup(snap_q.vowel, snap_q.vcnt);
    ti     = final_lookup(snap_q.fin, snap_q.fcnt);
    hit    = snap_q.ok && vi.hit && ti.hit && (snap_q.init_idx < InitCount);
    lv     = 9'(snap_q.init_idx) * 9'(VowelCount) + 9'(vi.idx);
    offs   = 14'(lv) * 14'(FinalCount) + 14'(ti.idx);
    code_d = hit ? SBase + 16'(offs) : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (e_ready) e_valid_q <= accept && s_axis_tlast;
      if (o_ready) o_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tlast) snap_q <= snap_d;
    if (o_ready && e_valid_q) begin
      found_q <= hit;
      code_q  <= code_d;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = code_q;
  assign m_axis_tuser  = found_q;

  a_found_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata >= SBase && m_axis_tdata <= SLast)
    else $error("found code point outside the syllable block");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("code point not zero on a miss");

  a_last_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> e_valid_q)
    else $error("last character did not load the evaluation stage");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_valid_q && o_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted with both stages full");

endmodule
